@@ rtl/hashed_page_table_core_assert.svh @@
// assertion macros for the hashed page table core
// used by rtl/hashed_page_table_core.sv; no other dependencies
`ifndef HASHED_PAGE_TABLE_CORE_ASSERT_SVH
`define HASHED_PAGE_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// property checked only outside reset
`define HPT_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hpt assertion failed");

// property that also covers the reset cycles
`define HPT_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hpt reset assertion failed");

`else

`define HPT_ASSERT(label, clk, rstn, prop)
`define HPT_ASSERT_RST(label, clk, prop)

`endif

`endif

@@ rtl/hpt_pkg.sv @@
// shared constants for the hashed page table core
// no dependencies; used by rtl/hashed_page_table_core.sv
package hpt_pkg;

    // table geometry
    localparam int NUM_BUCKETS = 64;
    localparam int WAYS        = 4;
    localparam int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;

    // field widths
    localparam int REQ_W    = 2;
    localparam int PAGE_W   = 20;
    localparam int FRAME_W  = 16;
    localparam int STATUS_W = 3;
    localparam int ENT_W    = PAGE_W + FRAME_W;
    localparam int ROW_W    = WAYS * ENT_W;

    // stream packing, padded to whole bytes
    localparam int S_TDATA_W = ((ENT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FRAME_W + 7) / 8) * 8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SET      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

    typedef logic [WAYS-1:0] way_vec_t;

endpackage

@@ rtl/hashed_page_table_core.sv @@
// hashed page table core: bucket row memory, valid flags and request sequencer
// depends on rtl/hpt_pkg.sv and rtl/hashed_page_table_core_assert.svh
//
// Usage:
//   s_ channel carries one request per transaction: s_tuser holds the
//   request kind (lookup/insert, set frame, remove), s_tdata the page and
//   the frame. m_ channel returns exactly one result per request: m_tuser
//   holds the status, m_tdata the stored frame on a hit, else zero.
//   Each request first reads the bucket row from the synchronous row
//   memory, then compares the ways and writes the updated row back while
//   the result is written into the output register. A new request is
//   taken only once the previous one has left its compare stage, that is
//   while the sequencer is idle.
//   If the receiver stalls, the finished result waits in the output
//   register; the next request is still taken and read, and it holds in its
//   compare stage until the output register frees up.
//   Reset clears all valid flags at once (flip-flops), so the table is
//   empty on the first cycle after aresetn rises; page and frame storage is
//   not cleared and is only read for valid entries.
module hashed_page_table_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [hpt_pkg::S_TDATA_W-1:0]   s_tdata,   // page[19:0], frame[35:20], zero pad
    input  logic [hpt_pkg::REQ_W-1:0]       s_tuser,   // req_type[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [hpt_pkg::M_TDATA_W-1:0]   m_tdata,   // frame_out[15:0]
    output logic [hpt_pkg::STATUS_W-1:0]    m_tuser    // status[2:0]
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    // control state
    logic                          state_reg, state_next;
    logic                          m_tvalid_reg, m_tvalid_next;
    hpt_pkg::way_vec_t             valid_reg [hpt_pkg::NUM_BUCKETS];

    // request and result payload
    logic [hpt_pkg::REQ_W-1:0]     req_reg;
    logic [hpt_pkg::PAGE_W-1:0]    page_reg;
    logic [hpt_pkg::FRAME_W-1:0]   frame_reg;
    logic [hpt_pkg::BKT_W-1:0]     bkt_reg;
    logic [hpt_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [hpt_pkg::FRAME_W-1:0]   fout_reg, fout_next;

    // row memory
    logic [hpt_pkg::ROW_W-1:0]     row_mem [hpt_pkg::NUM_BUCKETS];
    logic [hpt_pkg::ROW_W-1:0]     row_rd_reg;
    logic [hpt_pkg::ROW_W-1:0]     row_wr;

    logic                          s_accept;
    logic                          exec_done;
    logic [hpt_pkg::PAGE_W-1:0]    s_page;
    logic [hpt_pkg::FRAME_W-1:0]   s_frame;
    logic [hpt_pkg::BKT_W-1:0]     s_bkt;

    hpt_pkg::way_vec_t             vrow;
    hpt_pkg::way_vec_t             vrow_new;
    hpt_pkg::way_vec_t             hit_vec;
    logic                          hit_found;
    logic                          free_found;
    logic [hpt_pkg::WAY_W-1:0]     hit_idx;
    logic [hpt_pkg::WAY_W-1:0]     free_idx;

    // input unpacking and handshake
    assign s_page    = s_tdata[hpt_pkg::PAGE_W-1:0];
    assign s_frame   = s_tdata[hpt_pkg::ENT_W-1:hpt_pkg::PAGE_W];
    assign s_bkt     = hpt_pkg::BKT_W'(s_page % hpt_pkg::NUM_BUCKETS);
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign exec_done = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);

    // output port
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = hpt_pkg::M_TDATA_W'(fout_reg);

    // way compare and lowest hit / lowest free search
    assign vrow = valid_reg[bkt_reg];

    always_comb begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int w = hpt_pkg::WAYS - 1; w >= 0; w--) begin
            hit_vec[w] = vrow[w] &&
                (row_rd_reg[w*hpt_pkg::ENT_W +: hpt_pkg::PAGE_W] == page_reg);
            if (hit_vec[w]) begin
                hit_found = 1'b1;
                hit_idx   = hpt_pkg::WAY_W'(w);
            end
            if (!vrow[w]) begin
                free_found = 1'b1;
                free_idx   = hpt_pkg::WAY_W'(w);
            end
        end
    end

    // request execution: result and updated row
    always_comb begin
        status_next = hpt_pkg::ST_NOTFOUND;
        fout_next   = '0;
        row_wr      = row_rd_reg;
        vrow_new    = vrow;
        case (req_reg)
            hpt_pkg::REQ_LOOKUP: begin
                if (hit_found) begin
                    status_next = hpt_pkg::ST_HIT;
                    fout_next   = row_rd_reg[32'(hit_idx)*hpt_pkg::ENT_W + hpt_pkg::PAGE_W
                                             +: hpt_pkg::FRAME_W];
                end else if (free_found) begin
                    status_next = hpt_pkg::ST_INSERTED;
                    row_wr[32'(free_idx)*hpt_pkg::ENT_W +: hpt_pkg::ENT_W] =
                        {{hpt_pkg::FRAME_W{1'b0}}, page_reg};
                    vrow_new[free_idx] = 1'b1;
                end else begin
                    status_next = hpt_pkg::ST_FULL;
                end
            end
            hpt_pkg::REQ_SET: begin
                if (hit_found) begin
                    status_next = hpt_pkg::ST_SET;
                    row_wr[32'(hit_idx)*hpt_pkg::ENT_W + hpt_pkg::PAGE_W
                           +: hpt_pkg::FRAME_W] = frame_reg;
                end
            end
            hpt_pkg::REQ_REMOVE: begin
                if (hit_found) begin
                    status_next = hpt_pkg::ST_REMOVED;
                    vrow_new[hit_idx] = 1'b0;
                end
            end
            default: begin
                status_next = hpt_pkg::ST_NOTFOUND;
            end
        endcase
    end

    // sequencer and output valid
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (exec_done) begin
                    state_next    = S_IDLE;
                    m_tvalid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers and valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            for (int b = 0; b < hpt_pkg::NUM_BUCKETS; b++) begin
                valid_reg[b] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (exec_done) begin
                valid_reg[bkt_reg] <= vrow_new;
            end
        end
    end

    // request capture and result register
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg   <= s_tuser;
            page_reg  <= s_page;
            frame_reg <= s_frame;
            bkt_reg   <= s_bkt;
        end
        if (exec_done) begin
            status_reg <= status_next;
            fout_reg   <= fout_next;
        end
    end

    // bucket row memory, one read and one write port
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            row_rd_reg <= row_mem[s_bkt];
        end
        if (exec_done) begin
            row_mem[bkt_reg] <= row_wr;
        end
    end

    // checks
`include "hashed_page_table_core_assert.svh"

    `HPT_ASSERT(a_exec_gives_result, aclk, aresetn, (state_reg == S_EXEC && !m_tvalid_reg) |=> m_tvalid_reg)
    `HPT_ASSERT(a_status_range, aclk, aresetn, m_tvalid |-> (m_tuser <= hpt_pkg::ST_NOTFOUND))
    `HPT_ASSERT(a_frame_zero_on_miss, aclk, aresetn, (m_tvalid && m_tuser != hpt_pkg::ST_HIT) |-> (m_tdata == '0))
    `HPT_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> (valid_reg[0] == '0 && !m_tvalid))

endmodule

@@ test/tb_hashed_page_table_core.sv @@
// testbench for hashed_page_table_core: lookup/insert, set frame and remove requests
// with a shadow copy of the bucket table; depends on rtl/hpt_pkg.sv and the core
`timescale 1ns / 1ps

module tb_hashed_page_table_core;

    localparam int NUM_ENTRIES  = hpt_pkg::NUM_BUCKETS * hpt_pkg::WAYS;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TAG_W        = hpt_pkg::PAGE_W - hpt_pkg::BKT_W;

    // request code the core ignores
    localparam logic [hpt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [hpt_pkg::STATUS_W-1:0] status;
        logic [hpt_pkg::FRAME_W-1:0]  frame;
    } reply_t;

    typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_THIRD, RDY_LONG_STALL} ready_mode_t;

    logic                             aclk;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [hpt_pkg::S_TDATA_W-1:0]    s_tdata  = '0;   // page[19:0], frame[35:20], zero pad
    logic [hpt_pkg::REQ_W-1:0]        s_tuser  = '0;   // req_type[1:0]
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [hpt_pkg::M_TDATA_W-1:0]    m_tdata;         // frame_out[15:0]
    logic [hpt_pkg::STATUS_W-1:0]     m_tuser;         // status[2:0]

    // shadow copy of the page table
    bit                               shadow_valid [NUM_ENTRIES];
    logic [hpt_pkg::PAGE_W-1:0]       shadow_page  [NUM_ENTRIES];
    logic [hpt_pkg::FRAME_W-1:0]      shadow_frame [NUM_ENTRIES];

    reply_t                pending_replies [$];
    int                    err_count   = 0;
    int                    cycle_count = 0;
    int                    burst_left  = 0;

    ready_mode_t           ready_mode  = RDY_ALWAYS;
    int                    mode_cycles = 0;
    int                    ready_tick  = 0;

    hashed_page_table_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // expected reply of one request; updates the shadow table like the core does
    function automatic reply_t resolve_request(logic [hpt_pkg::REQ_W-1:0] kind,
                                               logic [hpt_pkg::PAGE_W-1:0] pg,
                                               logic [hpt_pkg::FRAME_W-1:0] fr);
        reply_t r;
        int     base;
        int     hit_idx;
        r.status = hpt_pkg::ST_NOTFOUND;
        r.frame  = '0;
        base     = int'(pg % hpt_pkg::NUM_BUCKETS) * hpt_pkg::WAYS;
        hit_idx  = -1;
        for (int w = 0; w < hpt_pkg::WAYS; w++) begin
            if (hit_idx < 0 && shadow_valid[base + w] && shadow_page[base + w] == pg)
                hit_idx = base + w;
        end
        case (kind)
            hpt_pkg::REQ_LOOKUP: begin
                if (hit_idx >= 0) begin
                    r.status = hpt_pkg::ST_HIT;
                    r.frame  = shadow_frame[hit_idx];
                end else begin
                    // miss: claim the lowest free way, if any
                    r.status = hpt_pkg::ST_FULL;
                    for (int w = 0; w < hpt_pkg::WAYS; w++) begin
                        if (r.status == hpt_pkg::ST_FULL && !shadow_valid[base + w]) begin
                            shadow_valid[base + w] = 1'b1;
                            shadow_page[base + w]  = pg;
                            shadow_frame[base + w] = '0;
                            r.status = hpt_pkg::ST_INSERTED;
                        end
                    end
                end
            end
            hpt_pkg::REQ_SET: begin
                if (hit_idx >= 0) begin
                    shadow_frame[hit_idx] = fr;
                    r.status = hpt_pkg::ST_SET;
                end
            end
            hpt_pkg::REQ_REMOVE: begin
                if (hit_idx >= 0) begin
                    shadow_valid[hit_idx] = 1'b0;
                    r.status = hpt_pkg::ST_REMOVED;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result check, then prediction of the request taken at the same edge
    always @(posedge aclk) begin
        reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result transaction: status %0d frame_out 0x%04h",
                       m_tuser, m_tdata);
                err_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    err_count++;
                end
                if (m_tdata !== want.frame) begin
                    $error("frame_out: expected 0x%04h, actual 0x%04h", want.frame, m_tdata);
                    err_count++;
                end
            end
        end
        if (aresetn && s_tvalid && s_tready)
            pending_replies.push_back(resolve_request(s_tuser,
                                          s_tdata[hpt_pkg::PAGE_W-1:0],
                                          s_tdata[hpt_pkg::PAGE_W +: hpt_pkg::FRAME_W]));
    end

    // receiver backpressure, switching between patterns
    always @(posedge aclk) begin
        if (mode_cycles == 0) begin
            ready_mode  = ready_mode_t'($urandom_range(0, 3));
            mode_cycles = $urandom_range(40, 200);
        end
        mode_cycles--;
        ready_tick++;
        case (ready_mode)
            RDY_ALWAYS:     m_tready <= 1'b1;
            RDY_COIN:       m_tready <= ($urandom_range(0, 1) == 1);
            RDY_THIRD:      m_tready <= (ready_tick % 3 == 0);
            default:        m_tready <= (ready_tick % 16 >= 10);
        endcase
    end

    // one request transaction, sent in bursts with random gaps between them
    task automatic send_req(input logic [hpt_pkg::REQ_W-1:0] kind,
                            input logic [hpt_pkg::PAGE_W-1:0] pg,
                            input logic [hpt_pkg::FRAME_W-1:0] fr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(hpt_pkg::S_TDATA_W - hpt_pkg::PAGE_W - hpt_pkg::FRAME_W){1'b0}},
                     fr, pg};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // hold off the sender until every reply is back
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_replies.size() != 0) @(posedge aclk);
    endtask

    // field extremes, each request kind and the corner cases
    task automatic test_directed();
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00000, 16'h0000);  // insert into empty bucket
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00000, 16'hFFFF);  // hit with frame 0
        send_req(hpt_pkg::REQ_SET,    20'h00000, 16'hFFFF);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00000, 16'h0000);
        send_req(hpt_pkg::REQ_SET,    20'h00040, 16'h1234);  // set on absent page
        send_req(hpt_pkg::REQ_REMOVE, 20'h00080, 16'h0000);  // remove of absent page
        send_req(hpt_pkg::REQ_LOOKUP, 20'hFFFFF, 16'h0000);  // last bucket
        send_req(hpt_pkg::REQ_SET,    20'hFFFFF, 16'hA5A5);
        send_req(hpt_pkg::REQ_LOOKUP, 20'hFFFFF, 16'h0000);
        // fill bucket 0, then overflow it
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00040, 16'h0000);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00080, 16'h0000);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h000C0, 16'h0000);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00100, 16'h0000);
        // hole in way 1, search past it, then refill it
        send_req(hpt_pkg::REQ_REMOVE, 20'h00040, 16'h0000);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00080, 16'h0000);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00100, 16'h0000);
        // unused request code leaves the table alone
        send_req(REQ_UNUSED,          20'h00000, 16'hFFFF);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h00000, 16'h0000);
        send_req(hpt_pkg::REQ_REMOVE, 20'h00000, 16'h0000);
        send_req(hpt_pkg::REQ_REMOVE, 20'h00000, 16'h0000);
        // alternating bit patterns
        send_req(hpt_pkg::REQ_LOOKUP, 20'hAAAAA, 16'h0000);
        send_req(hpt_pkg::REQ_SET,    20'hAAAAA, 16'h5555);
        send_req(hpt_pkg::REQ_LOOKUP, 20'h55555, 16'h0000);
        send_req(hpt_pkg::REQ_SET,    20'h55555, 16'hAAAA);
        send_req(hpt_pkg::REQ_LOOKUP, 20'hAAAAA, 16'h0000);
    endtask

    // random kind: mostly lookups, then sets, removes and a few unused codes
    function automatic logic [hpt_pkg::REQ_W-1:0] pick_kind();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)      return hpt_pkg::REQ_LOOKUP;
        else if (roll < 75) return hpt_pkg::REQ_SET;
        else if (roll < 95) return hpt_pkg::REQ_REMOVE;
        else                return REQ_UNUSED;
    endfunction

    // few buckets, more pages than ways: full buckets, holes and refills
    task automatic test_crowded_buckets(input int n_items);
        logic [TAG_W-1:0]                tag_pool [7];
        logic [hpt_pkg::BKT_W-1:0]       bkt;
        foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom());
        for (int n = 0; n < n_items; n++) begin
            bkt = ($urandom_range(0, 4) == 0) ? hpt_pkg::BKT_W'(hpt_pkg::NUM_BUCKETS - 1)
                                              : hpt_pkg::BKT_W'($urandom_range(0, 2));
            send_req(pick_kind(), {tag_pool[$urandom_range(0, 6)], bkt}, 16'($urandom()));
        end
    endtask

    // pages over the whole range, reusing recently named ones
    task automatic test_sparse_pages(input int n_items);
        logic [hpt_pkg::PAGE_W-1:0] recent_pages [$];
        logic [hpt_pkg::PAGE_W-1:0] pg;
        logic [hpt_pkg::REQ_W-1:0]  kind;
        for (int n = 0; n < n_items; n++) begin
            kind = pick_kind();
            if (recent_pages.size() == 0 || $urandom_range(0, 9) < 4)
                pg = hpt_pkg::PAGE_W'($urandom());
            else
                pg = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            if (kind == hpt_pkg::REQ_LOOKUP) begin
                recent_pages.push_back(pg);
                if (recent_pages.size() > 32) void'(recent_pages.pop_front());
            end
            send_req(kind, pg, 16'($urandom()));
        end
    endtask

    // test sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        wait_idle();
        test_crowded_buckets(500);
        wait_idle();
        test_sparse_pages(525);
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && pending_replies.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
